### hw/rtl/bfs_pkg.sv
// Shared constants, opcode codes and the bit-operation helper for the bit field store.
// Used by the top level; depends on nothing.
package bfs_pkg;

	// Store geometry.
	localparam int STORE_WORDS = 64;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;
	localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int CAP         = STORE_WORDS * WORD_W;

	// Field widths of the ports.
	localparam int OPC_W = 4;
	localparam int OFF_W = 11;
	localparam int WID_W = 7;
	localparam int VAL_W = 64;
	localparam int CNT_W = 12;

	// A field of up to 64 bits starting anywhere in a word touches at most three words.
	localparam int WIN_WORDS = 3;
	localparam int WIN_W     = WIN_WORDS * WORD_W;
	localparam int WIDX_W    = OFF_W - BIT_W + 1;
	localparam int LIM_W     = ($clog2(CAP + 1) > CNT_W) ? $clog2(CAP + 1) : CNT_W;

	localparam logic [CNT_W-1:0] CNT_RESET = 12'd2048;
	localparam logic [WID_W-1:0] MAX_WIDTH = 7'd64;

	// Opcodes.
	localparam logic [OPC_W-1:0] OP_READ  = 4'd0;
	localparam logic [OPC_W-1:0] OP_WRITE = 4'd1;
	localparam logic [OPC_W-1:0] OP_SET   = 4'd2;
	localparam logic [OPC_W-1:0] OP_AND   = 4'd3;
	localparam logic [OPC_W-1:0] OP_OR    = 4'd4;
	localparam logic [OPC_W-1:0] OP_XOR   = 4'd5;
	localparam logic [OPC_W-1:0] OP_NAND  = 4'd6;
	localparam logic [OPC_W-1:0] OP_NOR   = 4'd7;
	localparam logic [OPC_W-1:0] OP_XNOR  = 4'd8;
	localparam logic [OPC_W-1:0] OP_NOT   = 4'd9;

	// New value of a single bit after a set or logic operation.
	function automatic logic new_bit(input logic [OPC_W-1:0] opc, input logic cur,
			input logic flg);
		logic nb;
		case (opc)
			OP_SET:  nb = flg;
			OP_AND:  nb = cur & flg;
			OP_OR:   nb = cur | flg;
			OP_XOR:  nb = cur ^ flg;
			OP_NAND: nb = ~(cur & flg);
			OP_NOR:  nb = ~(cur | flg);
			OP_XNOR: nb = ~(cur ^ flg);
			OP_NOT:  nb = ~cur;
			default: nb = 1'b0;
		endcase
		return nb;
	endfunction

endpackage

### hw/rtl/bit_addressable_field_store.sv
// Top level of the bit field store: handshakes, sequencer and field merge datapath.
// Depends on bfs_pkg and on the word RAM bfs_ram.
//
// The store holds 64 words of 32 bits with bits numbered most significant first in each
// word, and it reads as all zeros after reset. One item is worked at a time: its three
// touched words are read from the word RAM one a cycle, merged in a 96-bit
// window and, for write and single-bit operations, written back one a cycle. From the
// beat that accepts an item, the sequencer steps through the read states, a merge state
// and, for a field write or a single-bit operation, the write-back states before the
// result is loaded into the output register; the next item is taken the cycle after the
// result is loaded, even while that result still waits for the downstream side.
// Words never written since reset read as zero through per-word valid flags, so there
// is no clearing pass. bit_count may be written at any time the block is idle.
module bit_addressable_field_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bfs_pkg::OPC_W-1:0] opcode,
	input  logic [bfs_pkg::OFF_W-1:0] bit_offset,
	input  logic [bfs_pkg::WID_W-1:0] field_width,
	input  logic [bfs_pkg::VAL_W-1:0] write_value,
	input  logic                      flag,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bfs_pkg::VAL_W-1:0] read_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bfs_pkg::CNT_W-1:0] cfg_data
);

	localparam int AW     = bfs_pkg::AW;
	localparam int WIN_W  = bfs_pkg::WIN_W;
	localparam int WORD_W = bfs_pkg::WORD_W;
	localparam int LIM_W  = bfs_pkg::LIM_W;
	localparam int WIDX_W = bfs_pkg::WIDX_W;
	localparam int SH_W   = $clog2(WIN_W + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [1:0]       LAST_SLOT = 2'(bfs_pkg::WIN_WORDS - 1);
	localparam logic [SH_W-1:0]  WIN_SZ    = SH_W'(WIN_W);
	localparam logic [LIM_W-1:0] CAP_L     = LIM_W'(bfs_pkg::CAP);
	localparam logic [WIN_W-1:0] ONES      = '1;

	logic [2:0] state_q;
	logic [1:0] cnt_q;

	logic [bfs_pkg::CNT_W-1:0] bit_count_q;
	logic [bfs_pkg::OPC_W-1:0] opc_q;
	logic [bfs_pkg::OFF_W-1:0] off_q;
	logic [bfs_pkg::WID_W-1:0] wid_q;
	logic [bfs_pkg::VAL_W-1:0] val_q;
	logic                      flag_q;
	logic [SH_W-1:0]           relim_q;
	logic [WIN_W-1:0]          win_q;
	logic [bfs_pkg::VAL_W-1:0] res_q;
	logic                      out_valid_q;
	logic [bfs_pkg::VAL_W-1:0] read_value_q;
	logic                      valid_q [bfs_pkg::STORE_WORDS];

	logic                      rd_s1;
	logic [1:0]                slot_s1;
	logic                      hit_s1;

	logic [WIDX_W-1:0] widx;
	logic              in_store;
	logic [AW-1:0]     addr;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic [LIM_W-1:0] lim;
	logic [LIM_W-1:0] base;
	logic [LIM_W-1:0] rel;
	logic [SH_W-1:0]  relim;

	logic                      is_single;
	logic                      is_write;
	logic [SH_W-1:0]           w_eff;
	logic [SH_W-1:0]           lo;
	logic [SH_W-1:0]           hi;
	logic [SH_W-1:0]           hie;
	logic [SH_W-1:0]           sh;
	logic [WIN_W-1:0]          mask;
	logic                      cur;
	logic                      nb;
	logic                      in_bit;
	logic [bfs_pkg::VAL_W-1:0] wval;
	logic [WIN_W-1:0]          aligned;
	logic [WIN_W-1:0]          fld;
	logic [WIN_W-1:0]          new_win;
	logic [bfs_pkg::VAL_W-1:0] result;
	logic                      out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign read_value = read_value_q;

	// Word index of the window slot under work, shared by the read and write phases.
	always_comb begin
		widx     = {1'b0, off_q[bfs_pkg::OFF_W-1:bfs_pkg::BIT_W]} + WIDX_W'(cnt_q);
		in_store = (32'(widx) < bfs_pkg::STORE_WORDS);
		addr     = AW'(widx);
	end

	// Valid bit positions that remain from the window's first bit on, capped at the window.
	always_comb begin
		lim   = (LIM_W'(bit_count_q) < CAP_L) ? LIM_W'(bit_count_q) : CAP_L;
		base  = LIM_W'({off_q[bfs_pkg::OFF_W-1:bfs_pkg::BIT_W], {bfs_pkg::BIT_W{1'b0}}});
		rel   = (lim > base) ? (lim - base) : '0;
		relim = (rel > LIM_W'(WIN_W)) ? WIN_SZ : SH_W'(rel);
	end

	// Field merge over the three-word window; window bit WIN_W-1 is the first bit.
	always_comb begin
		is_single = (opc_q >= bfs_pkg::OP_SET) && (opc_q <= bfs_pkg::OP_NOT);
		is_write  = (opc_q == bfs_pkg::OP_WRITE) || is_single;
		if (is_single) begin
			w_eff = SH_W'(1);
		end else if (wid_q > bfs_pkg::MAX_WIDTH) begin
			w_eff = SH_W'(bfs_pkg::MAX_WIDTH);
		end else begin
			w_eff = SH_W'(wid_q);
		end
		lo      = SH_W'(off_q[bfs_pkg::BIT_W-1:0]);
		hi      = lo + w_eff;
		hie     = (hi < relim_q) ? hi : relim_q;
		mask    = (ONES >> lo) & ~(ONES >> hie);
		cur     = |(win_q & mask);
		in_bit  = |mask;
		nb      = bfs_pkg::new_bit(opc_q, cur, flag_q);
		wval    = is_single ? {{(bfs_pkg::VAL_W-1){1'b0}}, nb} : val_q;
		sh      = WIN_SZ - hi;
		aligned = {{(WIN_W-bfs_pkg::VAL_W){1'b0}}, wval} << sh;
		fld     = (win_q & mask) >> sh;
		new_win = (win_q & ~mask) | (aligned & mask);
		if (opc_q == bfs_pkg::OP_READ) begin
			result = fld[bfs_pkg::VAL_W-1:0];
		end else if (is_single) begin
			result = {{(bfs_pkg::VAL_W-1){1'b0}}, in_bit & nb};
		end else begin
			result = '0;
		end
	end

	// Word RAM write-back, one window word a cycle.
	always_comb begin
		ram_we = (state_q == ST_WR) && in_store;
		case (cnt_q)
			2'd0:    ram_wdata = win_q[WIN_W-1 -: WORD_W];
			2'd1:    ram_wdata = win_q[WIN_W-1-WORD_W -: WORD_W];
			default: ram_wdata = win_q[WORD_W-1:0];
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	bfs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(bfs_pkg::STORE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	// Sequencer: read three words, merge, write back if is_write, emit the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_LAST: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= is_write ? ST_WR : ST_DONE;
				end
				ST_WR: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Read pipeline tag: which slot the registered RAM data belongs to.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_RD);
		end
	end

	// Per-word written flags; a word never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bfs_pkg::STORE_WORDS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (ram_we) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= bfs_pkg::CNT_RESET;
		end else if (cfg_valid) begin
			bit_count_q <= cfg_data;
		end
	end

	// Output register, freed when downstream takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers: item fields, window, result.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opc_q  <= opcode;
			off_q  <= bit_offset;
			wid_q  <= field_width;
			val_q  <= write_value;
			flag_q <= flag;
		end
		if (state_q == ST_RD) begin
			relim_q <= relim;
			slot_s1 <= cnt_q;
			hit_s1  <= in_store && valid_q[addr];
		end
		if (rd_s1) begin
			case (slot_s1)
				2'd0:    win_q[WIN_W-1 -: WORD_W]        <= hit_s1 ? ram_rdata : '0;
				2'd1:    win_q[WIN_W-1-WORD_W -: WORD_W] <= hit_s1 ? ram_rdata : '0;
				default: win_q[WORD_W-1:0]               <= hit_s1 ? ram_rdata : '0;
			endcase
		end else if (state_q == ST_CALC) begin
			win_q <= new_win;
			res_q <= result;
		end
		if (out_load) begin
			read_value_q <= res_q;
		end
	end

endmodule

### hw/rtl/bfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; the bit field store uses it for its word array.
module bfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered; a read of the entry being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
